// File: rtl/core/lch_pkg.sv
// Shared constants, payload types and helpers for the line character histogram.
package lch_pkg;

  localparam int MAX_LINES    = 128;
  localparam int NUM_BINS     = 128;
  localparam int COUNT_WIDTH  = 16;
  localparam int RUN_W        = 16;

  localparam int BIN_W        = $clog2(NUM_BINS);
  localparam int LINE_ADDR_W  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int LINE_IDX_W   = $clog2(MAX_LINES + 1);
  localparam int STORE_ADDR_W = LINE_ADDR_W + BIN_W;
  localparam int STORE_DEPTH  = MAX_LINES * NUM_BINS;

  // result queue
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // config port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_SEL_LF_PRESENT = 1'b0;  // paddr[2] of lf_present

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [7:0] CODE_LF = 8'd10;
  localparam logic [7:0] CODE_CR = 8'd13;
  localparam logic [7:0] CODE_SP = 8'd32;
  localparam logic [7:0] CODE_DQ = 8'd34;
  localparam logic [7:0] CODE_SQ = 8'd39;
  localparam logic [7:0] CODE_S  = 8'd115;

  localparam logic [BIN_W-1:0] BIN_SP = BIN_W'(CODE_SP);
  localparam logic [BIN_W-1:0] BIN_S  = BIN_W'(CODE_S);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [RUN_W-1:0]       RUN_MAX   = '1;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
    logic [7:0] next_byte;
    logic [7:0] second_next_byte;
    logic       last_of_data;
    logic [6:0] read_line;
    logic [6:0] read_bin;
  } item_t;

  typedef struct packed {
    logic [15:0] bin_count;
    logic [7:0]  lines_done;
    logic        line_ended;
    logic        double_quote_seen;
    logic        single_quote_seen;
    logic        store_full;
  } result_t;

  typedef struct packed {
    logic                    rd_en;
    logic [STORE_ADDR_W-1:0] addr;
    logic                    inc;
  } store_req_t;

  typedef struct packed {
    logic [7:0] lines_done;
    logic       line_ended;
    logic       dquote;
    logic       squote;
    logic       full;
  } line_status_t;

  function automatic logic [COUNT_WIDTH-1:0] count_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  // space and run bins live in the per-line space rows, not the bin store
  function automatic logic is_space_bin(input logic [BIN_W-1:0] bin);
    return (bin == BIN_SP) || (bin == BIN_S);
  endfunction

endpackage

// File: rtl/core/lch_line_ctrl.sv
// Per-line parse state, newline detection and the per-line space/run rows.
module lch_line_ctrl
  import lch_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  item_t                  item,
  input  logic                   lf_present,
  output line_status_t           status,
  output store_req_t             store_req,
  output logic [COUNT_WIDTH-1:0] space_count
);

  // state
  logic [LINE_IDX_W-1:0]  line_index, line_index_next;
  logic [RUN_W-1:0]       run, run_next;
  logic                   at_start, at_start_next;
  logic [1:0]             skip, skip_next;
  logic                   dq, dq_next;
  logic                   sq, sq_next;
  logic [COUNT_WIDTH-1:0] sp_cnt, sp_next;
  logic [COUNT_WIDTH-1:0] s_cnt, s_next;

  // space rows of closed lines: {space bin, run bin}
  logic [2*COUNT_WIDTH-1:0] space_mem [MAX_LINES];
  logic [2*COUNT_WIDTH-1:0] space_rdata;
  logic                     rd_cur, rd_mem_ok, rd_sel_s;
  logic [COUNT_WIDTH-1:0]   rd_cur_val;

  logic [7:0]             c, n1, n2;
  logic                   last, full, feed, eol, close, main_inc, is_read;
  logic [1:0]             eol_skip;
  logic [COUNT_WIDTH-1:0] sp_upd, s_upd;
  logic [31:0]            sp_w, run_w;

  assign is_read = accept && (item.command == CMD_READ);

  always_comb begin
    c    = item.data_byte;
    last = item.last_of_data;
    n1   = last ? 8'd0 : item.next_byte;
    n2   = last ? 8'd0 : item.second_next_byte;
    full = 32'(line_index) >= 32'(MAX_LINES);
    feed = accept && (item.command == CMD_BYTE) && !full;

    line_index_next = line_index;
    run_next        = run;
    at_start_next   = at_start;
    skip_next       = skip;
    dq_next         = dq;
    sq_next         = sq;
    sp_upd          = sp_cnt;
    s_upd           = s_cnt;
    sp_next         = sp_cnt;
    s_next          = s_cnt;
    eol             = 1'b0;
    eol_skip        = 2'd0;
    close           = 1'b0;
    main_inc        = 1'b0;
    sp_w            = 32'(sp_cnt);
    run_w           = 32'(run);

    if (feed) begin
      if (skip != 2'd0) begin
        // tail bytes of a multi-byte line end
        skip_next = last ? 2'd0 : skip - 2'd1;
      end else if (at_start && c == CODE_SP) begin
        close = last;
      end else begin
        at_start_next = 1'b0;
        if (!c[7]) begin
          main_inc = (c != CODE_SP) && (c != CODE_S);
          if (c == CODE_SP) begin
            sp_upd = count_inc(sp_cnt);
            if (run == '0) begin
              s_upd = count_inc(s_cnt);
            end
          end
          if (c == CODE_DQ) begin
            dq_next = 1'b1;
          end
          if (c == CODE_SQ) begin
            sq_next = 1'b1;
          end
          if (c == CODE_LF) begin
            eol      = 1'b1;
            eol_skip = (n1 == CODE_CR) ? 2'd1 : 2'd0;
          end else if (c == CODE_CR) begin
            if (n1 == CODE_LF) begin
              eol      = 1'b1;
              eol_skip = 2'd1;
            end else if (n1 == CODE_CR && n2 == CODE_LF) begin
              eol      = 1'b1;
              eol_skip = 2'd2;
            end else if (!lf_present) begin
              eol = 1'b1;
            end
          end
        end
        if (eol) begin
          // take trailing spaces back out
          sp_upd = (sp_w > run_w) ? COUNT_WIDTH'(sp_w - run_w) : '0;
          if (run != '0) begin
            s_upd = (s_cnt != '0) ? s_cnt - 1'b1 : '0;
          end
          close     = 1'b1;
          skip_next = last ? 2'd0 : eol_skip;
        end else begin
          if (c == CODE_SP) begin
            run_next = (run == RUN_MAX) ? run : run + 1'b1;
          end else begin
            run_next = '0;
          end
          close = last;
        end
      end
    end

    if (close) begin
      line_index_next = line_index + 1'b1;
      at_start_next   = 1'b1;
      run_next        = '0;
      sp_next         = '0;
      s_next          = '0;
    end else begin
      sp_next = sp_upd;
      s_next  = s_upd;
    end
  end

  always_comb begin
    status.lines_done = 8'(line_index_next);
    status.line_ended = close;
    status.dquote     = dq_next;
    status.squote     = sq_next;
    status.full       = 32'(line_index_next) >= 32'(MAX_LINES);

    store_req.rd_en = is_read || main_inc;
    store_req.inc   = main_inc;
    if (item.command == CMD_READ) begin
      store_req.addr = {LINE_ADDR_W'(item.read_line), item.read_bin};
    end else begin
      store_req.addr = {line_index[LINE_ADDR_W-1:0], c[BIN_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_index <= '0;
      run        <= '0;
      at_start   <= 1'b1;
      skip       <= 2'd0;
      dq         <= 1'b0;
      sq         <= 1'b0;
      sp_cnt     <= '0;
      s_cnt      <= '0;
    end else begin
      line_index <= line_index_next;
      run        <= run_next;
      at_start   <= at_start_next;
      skip       <= skip_next;
      dq         <= dq_next;
      sq         <= sq_next;
      sp_cnt     <= sp_next;
      s_cnt      <= s_next;
    end
  end

  // rows are written once, when their line closes; rows at or past the
  // current line are read but their data is never used
  always_ff @(posedge clk) begin
    if (close) begin
      space_mem[line_index[LINE_ADDR_W-1:0]] <= {sp_upd, s_upd};
    end
    if (is_read) begin
      space_rdata <= space_mem[LINE_ADDR_W'(item.read_line)];
    end
  end

  always_ff @(posedge clk) begin
    if (is_read) begin
      rd_cur     <= 32'(item.read_line) == 32'(line_index);
      rd_mem_ok  <= 32'(item.read_line) < 32'(line_index);
      rd_sel_s   <= item.read_bin == BIN_S;
      rd_cur_val <= (item.read_bin == BIN_S) ? s_cnt : sp_cnt;
    end
  end

  always_comb begin
    if (rd_cur) begin
      space_count = rd_cur_val;
    end else if (rd_mem_ok) begin
      space_count = rd_sel_s ? space_rdata[COUNT_WIDTH-1:0]
                             : space_rdata[2*COUNT_WIDTH-1:COUNT_WIDTH];
    end else begin
      space_count = '0;
    end
  end

endmodule

// File: rtl/core/lch_bin_store.sv
// Histogram bin store: dual-port RAM with read-modify-write, forwarding and a reset sweep.
module lch_bin_store
  import lch_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  store_req_t             req,
  output logic [COUNT_WIDTH-1:0] value,
  output logic                   busy
);

  logic [COUNT_WIDTH-1:0]  mem [STORE_DEPTH];
  logic [COUNT_WIDTH-1:0]  rdata;
  logic [STORE_ADDR_W-1:0] clr_addr, s1_addr, wb_addr;
  logic                    clr_busy, s1_inc, wb_valid;
  logic [COUNT_WIDTH-1:0]  wb_data, cur, inc_val;

  // last write bypasses the read that was taken at the same edge
  assign cur     = (wb_valid && wb_addr == s1_addr) ? wb_data : rdata;
  assign inc_val = count_inc(cur);
  assign value   = cur;
  assign busy    = clr_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
      s1_inc   <= 1'b0;
      wb_valid <= 1'b0;
    end else begin
      if (clr_busy) begin
        if (clr_addr == STORE_ADDR_W'(STORE_DEPTH - 1)) begin
          clr_busy <= 1'b0;
        end
        clr_addr <= clr_addr + 1'b1;
      end
      s1_inc <= req.inc;
      if (s1_inc) begin
        wb_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= req.addr;
    if (s1_inc) begin
      wb_addr <= s1_addr;
      wb_data <= inc_val;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= '0;
    end else if (s1_inc) begin
      mem[s1_addr] <= inc_val;
    end
    if (req.rd_en) begin
      rdata <= mem[req.addr];
    end
  end

  a_no_wb_in_sweep: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !s1_inc)
    else $error("bin write-back during clearing sweep");

  a_no_req_in_sweep: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !req.rd_en)
    else $error("store access during clearing sweep");

endmodule

// File: rtl/core/lch_out_queue.sv
// Result queue between the store pipeline and the result channel.
module lch_out_queue
  import lch_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  result_t           din,
  output logic              valid,
  input  logic              stall,
  output result_t           dout,
  output logic [QCNT_W-1:0] count
);

  result_t           slots [QDEPTH];
  logic [QPTR_W-1:0] rd_ptr, wr_ptr;
  logic              pop;

  assign valid = count != '0;
  assign pop   = valid && !stall;
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && count == QCNT_W'(QDEPTH)))
    else $error("result queue overflow");

endmodule

// File: rtl/core/line_char_histogram_unit.sv
// Top level of the per-line character histogram unit.
//
// Text is fed one beat per byte (command 0) with its two following bytes for
// newline lookahead; command 1 reads one bin of one line. Every beat gives
// exactly one result beat, in order. Each line's 7-bit code counts live in a
// 16384 x 16 bin store (line x code) that is read, incremented with
// saturation and written back; the space bin and the space-run bin of each
// line are kept in a separate 128-row store written when the line closes, so
// a byte touches at most one entry of each. After reset the bin store is
// swept to zero, one entry per cycle, and item_stall stays high until the sweep
// is done (configuration writes are taken meanwhile). After that one beat is
// taken every cycle while the result queue has room; a result beat is
// registered and pushed into the result queue before it is offered, and up to
// four results can be held while result_stall is high before item_stall rises.
// lf_present sits at APB byte address 0; write it only while no beat is in
// flight.
module line_char_histogram_unit
  import lch_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,

  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item_data,

  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result_data,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic                   lf_present;
  logic                   accept;
  line_status_t           status;
  store_req_t             store_req;
  logic [COUNT_WIDTH-1:0] space_count, store_value, count_sel;
  logic [31:0]            count_w;
  logic                   store_busy;

  // stage 1: store read data is back
  logic                   s1_valid;
  logic                   s1_cmd;
  logic                   s1_space;
  logic                   s1_range;
  line_status_t           s1_status;
  result_t                s1_result;

  logic [QCNT_W-1:0]      q_count;
  logic [QCNT_W:0]        occupancy;

  // ---- config register ----
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lf_present <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_SEL_LF_PRESENT) begin
      lf_present <= pwdata[0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_SEL_LF_PRESENT) begin
      prdata = {{(CFG_DATA_W-1){1'b0}}, lf_present};
    end else begin
      prdata = '0;
    end
  end

  // ---- flow control ----
  // everything in flight must fit the result queue, so the pipeline never
  // has to hold a stage back
  assign occupancy  = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_valid);
  assign item_stall = rst || store_busy || (occupancy >= (QCNT_W+1)'(QDEPTH));
  assign accept     = item_valid && !item_stall;

  lch_line_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (item_data),
    .lf_present  (lf_present),
    .status      (status),
    .store_req   (store_req),
    .space_count (space_count)
  );

  lch_bin_store u_store (
    .clk   (clk),
    .rst   (rst),
    .req   (store_req),
    .value (store_value),
    .busy  (store_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd    <= item_data.command;
    s1_space  <= is_space_bin(item_data.read_bin);
    s1_range  <= 32'(item_data.read_line) < 32'(MAX_LINES);
    s1_status <= status;
  end

  // ---- result assembly ----
  assign count_sel = s1_space ? space_count : store_value;
  assign count_w   = 32'(count_sel);

  always_comb begin
    s1_result.bin_count         = (s1_cmd == CMD_READ && s1_range) ? count_w[15:0] : 16'd0;
    s1_result.lines_done        = s1_status.lines_done;
    s1_result.line_ended        = s1_status.line_ended;
    s1_result.double_quote_seen = s1_status.dquote;
    s1_result.single_quote_seen = s1_status.squote;
    s1_result.store_full        = s1_status.full;
  end

  lch_out_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (s1_valid),
    .din   (s1_result),
    .valid (result_valid),
    .stall (result_stall),
    .dout  (result_data),
    .count (q_count)
  );

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |-> !store_busy)
    else $error("beat taken during clearing sweep");

endmodule
